// ===== hdl/ima_adpcm_wav_block_decoder_top_macros.svh =====
// Assertion macros used by the decoder module imawbd_decode.
// Both expect clk and rst_n in the scope where they are used.
`ifndef IMA_ADPCM_WAV_BLOCK_DECODER_TOP_MACROS_SVH
`define IMA_ADPCM_WAV_BLOCK_DECODER_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define IMAWBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imawbd: same-cycle check failed");
// next-cycle implication
`define IMAWBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imawbd: next-cycle check failed");
`else
`define IMAWBD_ASSERT_IMP(lbl, ante, cons)
`define IMAWBD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/imawbd_pkg.sv =====
package imawbd_pkg;

  // Step table and limits
  localparam int STEP_TABLE_SIZE = 89;
  localparam logic [6:0] MAX_INDEX = 7'd88;

  localparam logic [14:0] STEP_SIZES [STEP_TABLE_SIZE] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_ALIGN = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEREO = 1'b1;
  localparam logic [15:0] BLOCK_ALIGN_RESET = 16'd1024;

  // Work handed from the byte parser to the decoder
  typedef enum logic [1:0] {
    JOB_SKIP,
    JOB_HDR_SAMPLE,
    JOB_HDR_INDEX,
    JOB_DATA
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        ch;
    logic [15:0] word;  // header sample, or data/index byte in the low bits
  } job_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic               last;
  } out_item_t;

  // Index adjustment for the three magnitude bits of a nibble
  function automatic logic signed [4:0] index_delta(input logic [2:0] mag);
    logic signed [4:0] d;
    unique case (mag)
      3'd4:    d = 5'sd2;
      3'd5:    d = 5'sd4;
      3'd6:    d = 5'sd6;
      3'd7:    d = 5'sd8;
      default: d = -5'sd1;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/imawbd_nibble.sv =====
module imawbd_nibble (
  input  logic signed [15:0] pred,
  input  logic [6:0]         idx,
  input  logic [3:0]         nib,
  output logic signed [15:0] pred_nxt,
  output logic [6:0]         idx_nxt
);
  import imawbd_pkg::*;

  localparam logic signed [17:0] SUM_HI = 18'sd32767;
  localparam logic signed [17:0] SUM_LO = -18'sd32768;

  logic [6:0]         idx_c;
  logic [14:0]        step;
  logic [15:0]        diff;
  logic signed [17:0] pred_ext;
  logic signed [17:0] diff_ext;
  logic signed [17:0] sum;
  logic signed [4:0]  delta;
  logic signed [7:0]  idx_sum;

  // Step size and difference from the magnitude bits
  always_comb begin
    idx_c = (idx > MAX_INDEX) ? MAX_INDEX : idx;
    step  = STEP_SIZES[idx_c];
    diff  = {4'd0, step[14:3]}
          + (nib[2] ? {1'b0, step} : 16'd0)
          + (nib[1] ? {2'b00, step[14:1]} : 16'd0)
          + (nib[0] ? {3'b000, step[14:2]} : 16'd0);
  end

  // Predictor update with 16-bit saturation
  always_comb begin
    pred_ext = {{2{pred[15]}}, pred};
    diff_ext = $signed({2'b00, diff});
    sum = nib[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);
    if (sum > SUM_HI) begin
      pred_nxt = SUM_HI[15:0];
    end else if (sum < SUM_LO) begin
      pred_nxt = SUM_LO[15:0];
    end else begin
      pred_nxt = sum[15:0];
    end
  end

  // Step index update, clamped to the table
  always_comb begin
    delta   = index_delta(nib[2:0]);
    idx_sum = $signed({1'b0, idx_c}) + $signed({{3{delta[4]}}, delta});
    if (idx_sum < 8'sd0) begin
      idx_nxt = 7'd0;
    end else if (idx_sum > $signed({1'b0, MAX_INDEX})) begin
      idx_nxt = MAX_INDEX;
    end else begin
      idx_nxt = idx_sum[6:0];
    end
  end

endmodule

// ===== hdl/imawbd_parse.sv =====
module imawbd_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  imawbd_pkg::in_item_t in_item,
  input  logic [15:0]         block_align,
  input  logic                stereo,
  output imawbd_pkg::job_t    job
);
  import imawbd_pkg::*;

  logic [15:0] offset_r, offset_nxt;
  logic [7:0]  hdr_low_r, hdr_low_nxt;
  logic [15:0] off;
  logic        in_hdr;
  logic [16:0] off_inc;

  // Classify the byte by its place in the block
  always_comb begin
    off    = in_item.restart ? 16'd0 : offset_r;
    in_hdr = (off[15:3] == 13'd0) && (stereo || !off[2]);
    job.ch   = stereo & off[2];
    job.word = {8'd0, in_item.data_byte};
    job.kind = JOB_DATA;
    hdr_low_nxt = hdr_low_r;
    if (in_hdr) begin
      unique case (off[1:0])
        2'd0: begin
          job.kind = JOB_SKIP;
          if (accept) begin
            hdr_low_nxt = in_item.data_byte;
          end
        end
        2'd1: begin
          job.kind = JOB_HDR_SAMPLE;
          job.word = {in_item.data_byte, hdr_low_r};
        end
        2'd2:    job.kind = JOB_HDR_INDEX;
        default: job.kind = JOB_SKIP;
      endcase
    end
  end

  // Offset advance with wrap at the block end
  always_comb begin
    off_inc    = {1'b0, off} + 17'd1;
    offset_nxt = offset_r;
    if (accept) begin
      offset_nxt = (off_inc >= {1'b0, block_align}) ? 16'd0 : off_inc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= 16'd0;
      hdr_low_r <= 8'd0;
    end else begin
      offset_r  <= offset_nxt;
      hdr_low_r <= hdr_low_nxt;
    end
  end

endmodule

// ===== hdl/imawbd_decode.sv =====
`include "ima_adpcm_wav_block_decoder_top_macros.svh"

module imawbd_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_load,
  input  imawbd_pkg::job_t     job_in,
  output logic                 job_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output imawbd_pkg::out_item_t out_item
);
  import imawbd_pkg::*;

  logic              job_valid_r, job_valid_nxt;
  job_t              job_r;
  logic              phase_r, phase_nxt;
  logic signed [15:0] pred_r [2];
  logic [6:0]        idx_r [2];
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;

  logic              needs_out;
  logic              out_free;
  logic              step_go;
  logic              job_done;
  logic              out_load;
  logic [3:0]        nib;
  logic signed [15:0] nib_pred;
  logic [6:0]        nib_idx;
  logic [6:0]        hdr_idx;

  // One nibble per cycle unless out_stall holds the result: low on phase 0, high on phase 1
  assign nib = phase_r ? job_r.word[7:4] : job_r.word[3:0];

  imawbd_nibble u_nibble (
    .pred     (pred_r[job_r.ch]),
    .idx      (idx_r[job_r.ch]),
    .nib      (nib),
    .pred_nxt (nib_pred),
    .idx_nxt  (nib_idx)
  );

  assign hdr_idx = (job_r.word[7:0] > {1'b0, MAX_INDEX}) ? MAX_INDEX : job_r.word[6:0];

  // Step control
  always_comb begin
    needs_out = (job_r.kind == JOB_HDR_SAMPLE) || (job_r.kind == JOB_DATA);
    out_free  = !out_valid_r || !out_stall;
    step_go   = job_valid_r && (!needs_out || out_free);
    job_done  = step_go && ((job_r.kind != JOB_DATA) || phase_r);
    out_load  = step_go && needs_out;
    job_ready = !job_valid_r || job_done;

    job_valid_nxt = job_load ? 1'b1 : (job_done ? 1'b0 : job_valid_r);
    phase_nxt = phase_r;
    if (job_load || job_done) begin
      phase_nxt = 1'b0;
    end else if (step_go && (job_r.kind == JOB_DATA)) begin
      phase_nxt = 1'b1;
    end
    out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end
  end

  // Per-channel predictor and step index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r[0] <= 16'sd0;
      pred_r[1] <= 16'sd0;
      idx_r[0]  <= 7'd0;
      idx_r[1]  <= 7'd0;
    end else if (step_go) begin
      unique case (job_r.kind)
        JOB_HDR_SAMPLE: pred_r[job_r.ch] <= $signed(job_r.word);
        JOB_HDR_INDEX:  idx_r[job_r.ch]  <= hdr_idx;
        JOB_DATA: begin
          pred_r[job_r.ch] <= nib_pred;
          idx_r[job_r.ch]  <= nib_idx;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.sample  <= (job_r.kind == JOB_DATA) ? nib_pred : $signed(job_r.word);
      out_r.channel <= job_r.ch;
      out_r.last    <= (job_r.kind != JOB_DATA) || phase_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `IMAWBD_ASSERT_IMP(a_idx_range, 1'b1, (idx_r[0] <= MAX_INDEX) && (idx_r[1] <= MAX_INDEX))
  `IMAWBD_ASSERT_IMP(a_phase_data, phase_r, job_valid_r && (job_r.kind == JOB_DATA))
  `IMAWBD_ASSERT_IMP(a_data_two_steps, job_done && (job_r.kind == JOB_DATA), phase_r)
  `IMAWBD_ASSERT_NXT(a_first_not_last, out_load && (job_r.kind == JOB_DATA) && !phase_r, out_valid_r && !out_r.last)

endmodule

// ===== hdl/ima_adpcm_wav_block_decoder_top.sv =====
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_data  (data_byte, restart)
// out_     output     out_valid/out_stall out_data (sample, channel, last)
// cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// A header byte gives at most one sample, a data byte two: the shared nibble decoder
// and the single result register turn out one sample per cycle while out_stall is low.
// Reset (synchronous, rst_n low) clears the block offset, both channels'
// predictor and step index, and sets block_align to 1024, mono.
// in_stall rises while the current byte still has samples to deliver;
// out_stall holds the result register, and that backs up the input.
module ima_adpcm_wav_block_decoder_top (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  imawbd_pkg::in_item_t                     in_data,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output imawbd_pkg::out_item_t                    out_data,
  input  logic                                     cfg_we,
  input  logic [imawbd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [imawbd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import imawbd_pkg::*;

  logic [15:0] block_align_r, block_align_nxt;
  logic        stereo_r, stereo_nxt;
  logic        in_accept;
  logic        job_ready;
  job_t        job;

  // Configuration registers
  always_comb begin
    block_align_nxt = block_align_r;
    stereo_nxt      = stereo_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_ALIGN: block_align_nxt = cfg_wdata;
        CFG_STEREO:      stereo_nxt      = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_align_r <= BLOCK_ALIGN_RESET;
      stereo_r      <= 1'b0;
    end else begin
      block_align_r <= block_align_nxt;
      stereo_r      <= stereo_nxt;
    end
  end

  // Input transfer
  assign in_stall  = !job_ready;
  assign in_accept = in_valid && job_ready;

  imawbd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .in_item     (in_data),
    .block_align (block_align_r),
    .stereo      (stereo_r),
    .job         (job)
  );

  imawbd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_load  (in_accept),
    .job_in    (job),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_data)
  );

endmodule

// ===== tb/imawbd_check_pkg.sv =====
package imawbd_check_pkg;
  import imawbd_pkg::*;

  localparam int STEP_COUNT   = 89;
  localparam int TOP_INDEX    = 88;
  localparam int PCM_MAX      = 32767;
  localparam int PCM_MIN      = -32768;
  localparam int REPORT_LIMIT = 10;

  // IMA quantizer step sizes, one per step index
  localparam int STEP_LUT [STEP_COUNT] = '{
    7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31, 34, 37,
    41, 45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143, 157, 173,
    190, 209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658,
    724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066,
    2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484,
    7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500,
    20350, 22385, 24623, 27086, 29794, 32767
  };

  // Byte position inside one channel's 4-byte block header
  typedef enum logic [1:0] {
    HDR_SAMPLE_LO,
    HDR_SAMPLE_HI,
    HDR_INDEX,
    HDR_RESERVED
  } hdr_pos_t;

  // Tracks the decoder state and holds the samples still owed by the block
  class sample_scoreboard;
    logic [15:0]        block_len;
    logic               two_ch;
    logic [15:0]        offset;
    logic [7:0]         low_byte;
    logic signed [15:0] pred [2];
    logic [6:0]         step_idx [2];
    out_item_t          pending_samples [$];
    int                 errors;
    int                 bytes_in;
    int                 restarts;
    int                 checked;
    int                 railed;
    int                 settings;

    function new();
      block_len = 16'd1024;
      two_ch    = 1'b0;
      offset    = '0;
      low_byte  = '0;
      pred[0]   = '0;
      pred[1]   = '0;
      step_idx[0] = '0;
      step_idx[1] = '0;
      errors    = 0;
      bytes_in  = 0;
      restarts  = 0;
      checked   = 0;
      railed    = 0;
      settings  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_BLOCK_ALIGN) begin
        block_len = value;
      end else if (idx == CFG_STEREO) begin
        two_ch = value[0];
      end
      settings++;
    endfunction

    function int index_step(logic [2:0] mag);
      case (mag)
        3'd4:    return 2;
        3'd5:    return 4;
        3'd6:    return 6;
        3'd7:    return 8;
        default: return -1;
      endcase
    endfunction

    // One nibble through the channel's predictor and step index
    function logic signed [15:0] next_sample(logic ch, logic [3:0] nib);
      int step;
      int diff;
      int acc;
      int k;
      step = STEP_LUT[step_idx[ch]];
      diff = step >>> 3;
      if (nib[2]) diff += step;
      if (nib[1]) diff += step >>> 1;
      if (nib[0]) diff += step >>> 2;
      if (nib[3]) diff = -diff;
      acc = int'(pred[ch]) + diff;
      if (acc > PCM_MAX) acc = PCM_MAX;
      if (acc < PCM_MIN) acc = PCM_MIN;
      pred[ch] = 16'(acc);
      k = int'(step_idx[ch]) + index_step(nib[2:0]);
      if (k < 0) k = 0;
      if (k > TOP_INDEX) k = TOP_INDEX;
      step_idx[ch] = 7'(k);
      return pred[ch];
    endfunction

    function void expect_sample(logic signed [15:0] s, logic ch, logic lst);
      out_item_t e;
      e.sample  = s;
      e.channel = ch;
      e.last    = lst;
      if (int'(s) == PCM_MAX || int'(s) == PCM_MIN) railed++;
      pending_samples = {pending_samples, e};
    endfunction

    // Accepted input byte: advance the block walk and queue its samples
    function void note_transfer(in_item_t it);
      int          nxt;
      logic [15:0] hdr_end;
      logic [15:0] rel;
      logic        ch;
      bytes_in++;
      if (it.restart) begin
        offset = '0;
        restarts++;
      end
      hdr_end = two_ch ? 16'd8 : 16'd4;
      if (offset < hdr_end) begin
        ch = offset[2];
        case (hdr_pos_t'(offset[1:0]))
          HDR_SAMPLE_LO: low_byte = it.data_byte;
          HDR_SAMPLE_HI: begin
            pred[ch] = {it.data_byte, low_byte};
            expect_sample(pred[ch], ch, 1'b1);
          end
          HDR_INDEX: begin
            step_idx[ch] = (it.data_byte > TOP_INDEX) ? 7'(TOP_INDEX) : it.data_byte[6:0];
          end
          default: ;
        endcase
      end else begin
        // 4-byte nibble groups alternate channels in stereo
        rel = offset - hdr_end;
        ch  = two_ch & rel[2];
        expect_sample(next_sample(ch, it.data_byte[3:0]), ch, 1'b0);
        expect_sample(next_sample(ch, it.data_byte[7:4]), ch, 1'b1);
      end
      nxt = int'(offset) + 1;
      if (nxt >= int'(block_len)) nxt = 0;
      offset = 16'(nxt);
    endfunction

    // Accepted result: compare against the oldest owed sample
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_samples.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("unexpected sample %0d ch %0d last %0d, nothing pending",
                   got.sample, got.channel, got.last);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      checked++;
      if (got.sample !== want.sample || got.channel !== want.channel ||
          got.last !== want.last) begin
        if (errors < REPORT_LIMIT)
          $display("sample mismatch: want %0d ch %0d last %0d, got %0d ch %0d last %0d",
                   want.sample, want.channel, want.last,
                   got.sample, got.channel, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/ima_adpcm_wav_block_decoder_top_test.sv =====
module ima_adpcm_wav_block_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import imawbd_pkg::*;
  import imawbd_check_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 60;
  localparam int RUN_LIMIT_NS  = 1_000_000;

  // Random phases: block_align 0 means drawn, stereo ANY_MODE means drawn
  localparam int PHASES      = 9;
  localparam int ANY_MODE    = 2;
  localparam int HOLD_PHASE  = 3;
  localparam int PAUSE_PHASE = 5;
  localparam int PHASE_ALIGN  [PHASES] = '{8, 8, 9, 65535, 13, 1024, 12, 0, 0};
  localparam int PHASE_STEREO [PHASES] = '{1, 0, 1, 1, 0, 0, 1, ANY_MODE, ANY_MODE};
  localparam int PHASE_ITEMS  [PHASES] = '{100, 100, 110, 160, 130, 150, 100, 150, 150};

  localparam logic [7:0] EDGE_BYTES [8] = '{
    8'h00, 8'hFF, 8'h77, 8'hF7, 8'h7F, 8'h80, 8'h88, 8'h08
  };

  // Mono block at reset settings: min header sample, index clamp, rail hits
  localparam logic [7:0] MONO_DIRECTED [10] = '{
    8'h00, 8'h80, 8'hFF, 8'h5A, 8'h88, 8'hFF, 8'h77, 8'h77, 8'h77, 8'h00
  };
  // Stereo 16-byte block: both headers, then one nibble group per channel
  localparam logic [7:0] STEREO_DIRECTED [16] = '{
    8'hFF, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h00, 8'h58, 8'hFF,
    8'h12, 8'h34, 8'h56, 8'h9A, 8'hBC, 8'hDE, 8'hF0, 8'h11
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  sample_scoreboard sb;
  bit tx_calm;
  bit rx_calm;
  bit hold_off_req;
  int hold_offs;

  ima_adpcm_wav_block_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("ima_adpcm_wav_block_decoder_top_test: errors");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) return EDGE_BYTES[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  // One byte transfer, preceded by a random gap unless in a calm stretch
  task automatic send_byte(input logic [7:0] value, input logic first);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: value, restart: first};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(in_data);
  endtask

  // Stop sending and wait until every owed sample has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back, while the block is idle
  task automatic write_config(input logic [15:0] align, input logic stereo_on);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_ALIGN;
    cfg_wdata <= align;
    @(posedge clk);
    sb.set_reg(CFG_BLOCK_ALIGN, align);
    cfg_index <= CFG_STEREO;
    cfg_wdata <= CFG_DATA_W'(stereo_on);
    @(posedge clk);
    sb.set_reg(CFG_STEREO, CFG_DATA_W'(stereo_on));
    cfg_we <= 1'b0;
  endtask

  // Result side: check each transfer, then stall for a drawn number of cycles
  initial begin : result_sink
    int wait_cycles;
    wait_cycles = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        wait_cycles = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        wait_cycles  = LONG_HOLD;
        hold_offs++;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        wait_cycles--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int   align;
    logic stereo_on;
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_BLOCK_ALIGN;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: mono at reset settings, then a stereo block after a restart
    foreach (MONO_DIRECTED[i]) send_byte(MONO_DIRECTED[i], i == 0);
    drain_results();
    write_config(16'd16, 1'b1);
    foreach (STEREO_DIRECTED[i]) send_byte(STEREO_DIRECTED[i], i == 0);
    drain_results();

    // Random phases over several block sizes and channel modes
    for (int p = 0; p < PHASES; p++) begin
      align     = (PHASE_ALIGN[p] == 0) ? $urandom_range(8, 80) : PHASE_ALIGN[p];
      stereo_on = (PHASE_STEREO[p] == ANY_MODE) ? 1'($urandom_range(0, 1))
                                                : 1'(PHASE_STEREO[p]);
      write_config(16'(align), stereo_on);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (p == HOLD_PHASE && n == 40) hold_off_req = 1'b1;
        if (p == PAUSE_PHASE && n == 70) drain_results();
        send_byte(pick_byte(), $urandom_range(0, 49) == 0);
      end
      drain_results();
    end

    if (sb.pending_samples.size() != 0) sb.errors += sb.pending_samples.size();
    $display("run: %0d bytes in (%0d restarts) under %0d register writes, %0d long hold-offs",
             sb.bytes_in, sb.restarts, sb.settings, hold_offs);
    $display("run: %0d samples compared, %0d of them on a 16-bit rail, %0d mismatches",
             sb.checked, sb.railed, sb.errors);
    if (sb.errors == 0) begin
      $display("ima_adpcm_wav_block_decoder_top_test: clean");
    end else begin
      $display("ima_adpcm_wav_block_decoder_top_test: errors");
    end
    $finish;
  end

endmodule
